[sv/byte_stuff_frame_decoder_unit_assert.svh]
// Assertion macros for the byte-stuffing frame decoder.
// Expects signals named clk and arst_n in the including module's scope.
`ifndef BYTE_STUFF_FRAME_DECODER_UNIT_ASSERT_SVH
`define BYTE_STUFF_FRAME_DECODER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BSFD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the trigger.
`define BSFD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

[sv/bsfd_pkg.sv]
// Shared types and constants for the byte-stuffing frame decoder.
// No dependencies; imported by bsfd_step and the top level.
`default_nettype none

package bsfd_pkg;

	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START  = 2'd0,
		CFG_END    = 2'd1,
		CFG_ESCAPE = 2'd2
	} cfg_reg_t;

	localparam logic [7:0] START_CODE_RST  = 8'h7E;
	localparam logic [7:0] END_CODE_RST    = 8'h7D;
	localparam logic [7:0] ESCAPE_CODE_RST = 8'h7C;

	typedef enum logic [1:0] {
		MODE_HUNT = 2'd0,
		MODE_DATA = 2'd1,
		MODE_ESC  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] end_code;
		logic [7:0] escape_code;
	} codes_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] held_byte;
		logic       held_valid;
	} dec_state_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
	} dec_result_t;

endpackage

`default_nettype wire

[sv/bsfd_step.sv]
// One decode step: next framing state and optional result for one byte.
// Pure combinational; depends on bsfd_pkg.
`default_nettype none

module bsfd_step
	import bsfd_pkg::*;
(
	input  wire dec_state_t  cur,
	input  wire logic [7:0]  rx,
	input  wire codes_t      codes,
	output dec_state_t       nxt,
	output dec_result_t      res
);

	logic is_start;
	logic is_end;
	logic is_esc;

	assign is_start = (rx == codes.start_code);
	assign is_end   = (rx == codes.end_code);
	assign is_esc   = (rx == codes.escape_code);

	// next state
	always_comb begin
		nxt = cur;
		unique case (cur.mode)
			MODE_ESC: begin
				nxt.mode       = MODE_DATA;
				nxt.held_byte  = rx;
				nxt.held_valid = 1'b1;
			end
			MODE_DATA: begin
				if (is_end) begin
					// end test wins over escape test when codes collide
					nxt.mode       = MODE_HUNT;
					nxt.held_byte  = '0;
					nxt.held_valid = 1'b0;
				end else if (is_esc) begin
					nxt.mode = MODE_ESC;
				end else begin
					nxt.held_byte  = rx;
					nxt.held_valid = 1'b1;
				end
			end
			default: begin
				if (is_start) begin
					nxt.mode       = MODE_DATA;
					nxt.held_byte  = '0;
					nxt.held_valid = 1'b0;
				end else begin
					nxt.mode = MODE_HUNT;
				end
			end
		endcase
	end

	// result: the held byte leaves when displaced or when the frame closes
	always_comb begin
		res.data = cur.held_byte;
		res.emit = 1'b0;
		res.last = 1'b0;
		unique case (cur.mode)
			MODE_ESC: begin
				res.emit = cur.held_valid;
			end
			MODE_DATA: begin
				if (is_end) begin
					res.emit = cur.held_valid;
					res.last = 1'b1;
				end else if (!is_esc) begin
					res.emit = cur.held_valid;
				end
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/byte_stuff_frame_decoder_unit.sv]
// Top level of the byte-stuffing frame decoder: channels, registers, state.
// Depends on bsfd_pkg, bsfd_step and byte_stuff_frame_decoder_unit_assert.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | sink      | in_valid/in_stall  | rx_byte
//   out     | source    | out_valid/out_stall| payload_byte, frame_last
//   cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled. A byte is
// held in the input register and decoded there, and the result it releases
// (if any) is written into the output register as the byte leaves the input
// register. Bytes that yield no result retire without touching the output
// register. Reset clears the codes to their defaults, the framing state to
// hunting and both valid flags.
// in_stall rises only while the output register is full and stalled and the
// byte in the input register has a result to deliver.
`default_nettype none
`include "byte_stuff_frame_decoder_unit_assert.svh"

module byte_stuff_frame_decoder_unit
	import bsfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input byte channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              payload_byte,
	output logic                    frame_last,
	// register write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [7:0]         cfg_data
);

	codes_t      codes_q;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       adv_s1;
	logic       load_s1;

	// ---------------------------------------------------------------
	// Code registers; writes to unused indexes are dropped.
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code  <= START_CODE_RST;
			codes_q.end_code    <= END_CODE_RST;
			codes_q.escape_code <= ESCAPE_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START:  codes_q.start_code  <= cfg_data;
				CFG_END:    codes_q.end_code    <= cfg_data;
				CFG_ESCAPE: codes_q.escape_code <= cfg_data;
				default:    ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: input register. The held byte advances when it has no
	// result or when the output register can take one.
	// ---------------------------------------------------------------
	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Decode and framing state
	// ---------------------------------------------------------------
	bsfd_step u_step (
		.cur   (state_q),
		.rx    (byte_s1),
		.codes (codes_q),
		.nxt   (state_nxt),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= MODE_HUNT;
			state_q.held_byte  <= '0;
			state_q.held_valid <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			payload_byte <= res.data;
			frame_last   <= res.last;
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`BSFD_ASSERT(a_held_only_in_frame, !state_q.held_valid || state_q.mode != MODE_HUNT, "held byte while hunting")
	`BSFD_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall && res.emit), "input stalled without a blocked result")
	`BSFD_ASSERT(a_emit_needs_held, !(valid_s1 && res.emit) || state_q.held_valid, "result without a held byte")
	`BSFD_ASSERT_NEXT(a_last_closes, adv_s1 && res.emit && res.last, state_q.mode == MODE_HUNT && !state_q.held_valid, "frame not closed after last byte")

endmodule

`default_nettype wire
